// ----- hw/rtl/fxnc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the filtered-x LMS noise canceller.
// Used by the controller, the datapath and the top level; depends on nothing else.
package fxnc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ADAPT_TAPS  = 20;
    localparam int SEC_TAPS    = 5;
    localparam int WEIGHT_TAPS = 7;
    localparam int REF_DEPTH   = (ADAPT_TAPS > SEC_TAPS) ? ADAPT_TAPS : SEC_TAPS;

    localparam int FRAC_BITS   = 12;
    localparam int WFIR_FRAC   = 15;
    localparam int WGT_FRAC    = 24;
    localparam int STEP_FRAC   = 16;
    localparam int WGT_W       = 32;
    localparam int STEP_W      = 16;

    // Multiplier operand and accumulator widths.
    localparam int SE_W   = STEP_W + SAMPLE_BITS + 1;
    localparam int A_W    = (WGT_W > SE_W) ? WGT_W : SE_W;
    localparam int B_W    = ((STEP_W > SAMPLE_BITS) ? STEP_W : SAMPLE_BITS) + 1;
    localparam int P_W    = A_W + B_W;
    localparam int ACC_W  = P_W + $clog2(REF_DEPTH + WEIGHT_TAPS) + 2;

    // Sequencer counter and per-array index widths.
    localparam int MAX_LEN = (REF_DEPTH > WEIGHT_TAPS) ? REF_DEPTH : WEIGHT_TAPS;
    localparam int CNT_W   = $clog2(MAX_LEN + 2);
    localparam int IDX_W   = ($clog2(MAX_LEN) > 0) ? $clog2(MAX_LEN) : 1;
    localparam int REF_IW  = ($clog2(REF_DEPTH) > 0) ? $clog2(REF_DEPTH) : 1;
    localparam int ADP_IW  = ($clog2(ADAPT_TAPS) > 0) ? $clog2(ADAPT_TAPS) : 1;
    localparam int SEC_IW  = ($clog2(SEC_TAPS) > 0) ? $clog2(SEC_TAPS) : 1;
    localparam int WFT_IW  = $clog2(WEIGHT_TAPS);

    // Configuration register map.
    localparam int NUM_SEC_REGS  = 5;
    localparam int NUM_CFG_REGS  = NUM_SEC_REGS + 1;
    localparam int CFG_AW        = $clog2(NUM_CFG_REGS);
    localparam int REG_STEP_SIZE = NUM_SEC_REGS;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(26214);

    localparam logic signed [SAMPLE_BITS-1:0] SEC_RESET [NUM_SEC_REGS] = '{
        SAMPLE_BITS'(2048), SAMPLE_BITS'(492), SAMPLE_BITS'(4096),
        SAMPLE_BITS'(7373), SAMPLE_BITS'(6922)
    };

    // Weighting FIR taps, 0.2 scale folded in, signed Q0.15.
    localparam logic signed [15:0] WFIR_COEF [WEIGHT_TAPS] = '{
        16'sd4133, -16'sd8266, -16'sd4133, 16'sd16531, -16'sd4133, -16'sd8266, 16'sd4133
    };

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

    typedef enum logic [2:0] {OP_NONE, OP_LOAD, OP_MAC, OP_FIN, OP_OUT} op_t;

    // Processing phases, in the order that the sequencer runs them.
    typedef enum logic [2:0] {
        SRC_SECX, SRC_WFX, SRC_ADAPT, SRC_SECA, SRC_WFE, SRC_STEP, SRC_UPD
    } src_t;

    typedef struct packed {
        op_t              op;
        src_t             src;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    // Number of multiply-accumulates in each phase.
    function automatic logic [CNT_W-1:0] phase_len(input src_t s);
        logic [CNT_W-1:0] n;
        unique case (s)
            SRC_SECX, SRC_SECA: n = CNT_W'(SEC_TAPS);
            SRC_WFX, SRC_WFE:   n = CNT_W'(WEIGHT_TAPS);
            SRC_ADAPT, SRC_UPD: n = CNT_W'(ADAPT_TAPS);
            SRC_STEP:           n = CNT_W'(1);
            default:            n = CNT_W'(1);
        endcase
        return n;
    endfunction

    // Round half up, then arithmetic shift right.
    function automatic logic signed [ACC_W-1:0] rnd_shr(input logic signed [ACC_W-1:0] v,
                                                         input int s);
        logic signed [ACC_W-1:0] half;
        half = ACC_W'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_samp(
            input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (v > hi) return hi[SAMPLE_BITS-1:0];
        if (v < lo) return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (WGT_W - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (v > hi) return hi[WGT_W-1:0];
        if (v < lo) return lo[WGT_W-1:0];
        return v[WGT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/fxnc_ctrl.sv -----
// Sequencer for the noise canceller: runs the filter and update phases for one item.
// Depends on fxnc_pkg; drives the datapath through a cmd_t each cycle.
module fxnc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  fxnc_pkg::status_t    status,
    output fxnc_pkg::cmd_t       cmd
);

    localparam logic [fxnc_pkg::CNT_W-1:0] CNT_ONE = fxnc_pkg::CNT_W'(1);

    fxnc_pkg::state_t                 state_reg, state_next;
    fxnc_pkg::src_t                   src_reg, src_next;
    logic [fxnc_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [fxnc_pkg::CNT_W-1:0]       len;

    assign len = fxnc_pkg::phase_len(src_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fxnc_pkg::ST_IDLE;
            src_reg   <= fxnc_pkg::SRC_SECX;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            src_reg   <= src_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state: each phase issues its MACs, waits for the last product to drain, then finishes.
    always_comb begin
        state_next = state_reg;
        src_next   = src_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            fxnc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = fxnc_pkg::ST_RUN;
                    src_next   = fxnc_pkg::SRC_SECX;
                    cnt_next   = '0;
                end
            end
            fxnc_pkg::ST_RUN: begin
                if (cnt_reg == len + CNT_ONE) begin
                    cnt_next = '0;
                    if (src_reg == fxnc_pkg::SRC_UPD) begin
                        state_next = fxnc_pkg::ST_OUT;
                    end else begin
                        src_next = fxnc_pkg::src_t'(src_reg + 3'd1);
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            fxnc_pkg::ST_OUT: begin
                if (!status.out_full) begin
                    state_next = fxnc_pkg::ST_IDLE;
                end
            end
            default: state_next = fxnc_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        s_tready = 1'b0;
        cmd.op   = fxnc_pkg::OP_NONE;
        cmd.src  = src_reg;
        cmd.idx  = cnt_reg[fxnc_pkg::IDX_W-1:0];
        unique case (state_reg)
            fxnc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = fxnc_pkg::OP_LOAD;
            end
            fxnc_pkg::ST_RUN: begin
                if (cnt_reg < len) begin
                    cmd.op = fxnc_pkg::OP_MAC;
                end else if (cnt_reg != len) begin
                    cmd.op = fxnc_pkg::OP_FIN;
                end
            end
            fxnc_pkg::ST_OUT: begin
                if (!status.out_full) cmd.op = fxnc_pkg::OP_OUT;
            end
            default: cmd.op = fxnc_pkg::OP_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == fxnc_pkg::ST_RUN &&
                                    src_reg == fxnc_pkg::SRC_SECX && cnt_reg == '0))
        else $error("accepted item did not start the first phase");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fxnc_pkg::ST_RUN) |-> (cnt_reg <= len + CNT_ONE))
        else $error("phase counter ran past its phase");
    a_out_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fxnc_pkg::ST_OUT && !status.out_full) |=>
        (state_reg == fxnc_pkg::ST_IDLE))
        else $error("result hand-off did not return to idle");
`endif

endmodule

// ----- hw/rtl/fxnc_datapath.sv -----
// Datapath for the noise canceller: histories, weights, config registers, shared MAC.
// Depends on fxnc_pkg; executes the commands of fxnc_ctrl.
module fxnc_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  fxnc_pkg::cmd_t                          cmd,
    output fxnc_pkg::status_t                       status,
    input  logic signed [fxnc_pkg::SAMPLE_BITS-1:0] in_ref,
    input  logic signed [fxnc_pkg::SAMPLE_BITS-1:0] in_desired,
    input  logic                                    cfg_wen,
    input  logic [fxnc_pkg::CFG_AW-1:0]             cfg_addr,
    input  logic [fxnc_pkg::STEP_W-1:0]             cfg_wdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [4*fxnc_pkg::SAMPLE_BITS-1:0]      m_tdata
);

    localparam int SB = fxnc_pkg::SAMPLE_BITS;
    localparam int AW = fxnc_pkg::ACC_W;

    logic signed [SB-1:0]               sec_coef_reg [fxnc_pkg::SEC_TAPS];
    logic [fxnc_pkg::STEP_W-1:0]        step_reg;
    logic signed [fxnc_pkg::WGT_W-1:0]  wgt_reg      [fxnc_pkg::ADAPT_TAPS];
    logic signed [SB-1:0]               ref_hist_reg [fxnc_pkg::REF_DEPTH];
    logic signed [SB-1:0]               fr_hist_reg  [fxnc_pkg::ADAPT_TAPS];
    logic signed [SB-1:0]               sp_hist_reg  [fxnc_pkg::WEIGHT_TAPS];
    logic signed [SB-1:0]               an_hist_reg  [fxnc_pkg::SEC_TAPS];
    logic signed [SB-1:0]               err_hist_reg [fxnc_pkg::WEIGHT_TAPS];

    logic signed [SB-1:0]               d_reg, yout_reg, spk_reg, err_reg, eh_reg;
    logic signed [fxnc_pkg::SE_W-1:0]   se_reg;
    logic signed [AW-1:0]               acc_reg;
    logic signed [fxnc_pkg::P_W-1:0]    prod_reg;
    logic                               p_mac_reg, p_upd_reg;
    logic [fxnc_pkg::IDX_W-1:0]         p_idx_reg;
    logic                               out_valid_reg;
    logic [4*SB-1:0]                    out_data_reg;

    logic signed [fxnc_pkg::A_W-1:0]    op_a;
    logic signed [fxnc_pkg::B_W-1:0]    op_b;
    logic signed [fxnc_pkg::P_W-1:0]    prod;
    logic signed [AW-1:0]               rnd12, rnd15, rnd24;
    logic signed [SB-1:0]               spk_now;
    logic signed [AW-1:0]               upd_sum;
    logic [fxnc_pkg::REF_IW-1:0]        i_ref;
    logic [fxnc_pkg::ADP_IW-1:0]        i_adp, p_adp;
    logic [fxnc_pkg::SEC_IW-1:0]        i_sec;
    logic [fxnc_pkg::WFT_IW-1:0]        i_wft;

    assign i_ref = cmd.idx[fxnc_pkg::REF_IW-1:0];
    assign i_adp = cmd.idx[fxnc_pkg::ADP_IW-1:0];
    assign i_sec = cmd.idx[fxnc_pkg::SEC_IW-1:0];
    assign i_wft = cmd.idx[fxnc_pkg::WFT_IW-1:0];
    assign p_adp = p_idx_reg[fxnc_pkg::ADP_IW-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.src)
            fxnc_pkg::SRC_SECX: begin
                op_a = fxnc_pkg::A_W'(ref_hist_reg[i_ref]);
                op_b = fxnc_pkg::B_W'(sec_coef_reg[i_sec]);
            end
            fxnc_pkg::SRC_WFX: begin
                op_a = fxnc_pkg::A_W'(sp_hist_reg[i_wft]);
                op_b = fxnc_pkg::B_W'(fxnc_pkg::WFIR_COEF[i_wft]);
            end
            fxnc_pkg::SRC_ADAPT: begin
                op_a = fxnc_pkg::A_W'(wgt_reg[i_adp]);
                op_b = fxnc_pkg::B_W'(ref_hist_reg[i_ref]);
            end
            fxnc_pkg::SRC_SECA: begin
                op_a = fxnc_pkg::A_W'(an_hist_reg[i_sec]);
                op_b = fxnc_pkg::B_W'(sec_coef_reg[i_sec]);
            end
            fxnc_pkg::SRC_WFE: begin
                op_a = fxnc_pkg::A_W'(err_hist_reg[i_wft]);
                op_b = fxnc_pkg::B_W'(fxnc_pkg::WFIR_COEF[i_wft]);
            end
            fxnc_pkg::SRC_STEP: begin
                op_a = fxnc_pkg::A_W'(eh_reg);
                op_b = signed'(fxnc_pkg::B_W'({1'b0, step_reg}));
            end
            fxnc_pkg::SRC_UPD: begin
                op_a = fxnc_pkg::A_W'(se_reg);
                op_b = fxnc_pkg::B_W'(fr_hist_reg[i_adp]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod    = fxnc_pkg::P_W'(op_a) * fxnc_pkg::P_W'(op_b);
    assign rnd12   = fxnc_pkg::rnd_shr(acc_reg, fxnc_pkg::FRAC_BITS);
    assign rnd15   = fxnc_pkg::rnd_shr(acc_reg, fxnc_pkg::WFIR_FRAC);
    assign rnd24   = fxnc_pkg::rnd_shr(acc_reg, fxnc_pkg::WGT_FRAC);
    assign spk_now = fxnc_pkg::sat_samp(rnd12);
    assign upd_sum = AW'(wgt_reg[p_adp]) +
                     fxnc_pkg::rnd_shr(AW'(prod_reg), fxnc_pkg::STEP_FRAC);

    // Product register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_mac_reg <= 1'b0;
            p_upd_reg <= 1'b0;
        end else begin
            p_mac_reg <= (cmd.op == fxnc_pkg::OP_MAC) && (cmd.src != fxnc_pkg::SRC_UPD);
            p_upd_reg <= (cmd.op == fxnc_pkg::OP_MAC) && (cmd.src == fxnc_pkg::SRC_UPD);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= prod;
        p_idx_reg <= cmd.idx;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < fxnc_pkg::SEC_TAPS; j++) begin
                sec_coef_reg[j] <= (j < fxnc_pkg::NUM_SEC_REGS) ?
                                   fxnc_pkg::SEC_RESET[j] : '0;
            end
            step_reg <= fxnc_pkg::STEP_RESET;
        end else if (cfg_wen) begin
            for (int j = 0; j < fxnc_pkg::SEC_TAPS; j++) begin
                if (j < fxnc_pkg::NUM_SEC_REGS && int'(cfg_addr) == j) begin
                    sec_coef_reg[j] <= signed'(cfg_wdata[SB-1:0]);
                end
            end
            if (int'(cfg_addr) == fxnc_pkg::REG_STEP_SIZE) step_reg <= cfg_wdata;
        end
    end

    // Histories, weights, accumulator and phase results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < fxnc_pkg::ADAPT_TAPS; j++) begin
                wgt_reg[j]     <= '0;
                fr_hist_reg[j] <= '0;
            end
            for (int j = 0; j < fxnc_pkg::REF_DEPTH; j++) ref_hist_reg[j] <= '0;
            for (int j = 0; j < fxnc_pkg::WEIGHT_TAPS; j++) begin
                sp_hist_reg[j]  <= '0;
                err_hist_reg[j] <= '0;
            end
            for (int j = 0; j < fxnc_pkg::SEC_TAPS; j++) an_hist_reg[j] <= '0;
            acc_reg <= '0;
        end else begin
            if (p_mac_reg) acc_reg <= acc_reg + AW'(prod_reg);
            if (p_upd_reg) wgt_reg[p_adp] <= fxnc_pkg::sat_wgt(upd_sum);

            if (cmd.op == fxnc_pkg::OP_LOAD) begin
                for (int j = fxnc_pkg::REF_DEPTH - 1; j > 0; j--) begin
                    ref_hist_reg[j] <= ref_hist_reg[j-1];
                end
                ref_hist_reg[0] <= in_ref;
                d_reg           <= in_desired;
            end

            if (cmd.op == fxnc_pkg::OP_FIN) begin
                acc_reg <= '0;
                unique case (cmd.src)
                    fxnc_pkg::SRC_SECX: begin
                        for (int j = fxnc_pkg::WEIGHT_TAPS - 1; j > 0; j--) begin
                            sp_hist_reg[j] <= sp_hist_reg[j-1];
                        end
                        sp_hist_reg[0] <= spk_now;
                    end
                    fxnc_pkg::SRC_WFX: begin
                        for (int j = fxnc_pkg::ADAPT_TAPS - 1; j > 0; j--) begin
                            fr_hist_reg[j] <= fr_hist_reg[j-1];
                        end
                        fr_hist_reg[0] <= fxnc_pkg::sat_samp(rnd15);
                    end
                    fxnc_pkg::SRC_ADAPT: begin
                        for (int j = fxnc_pkg::SEC_TAPS - 1; j > 0; j--) begin
                            an_hist_reg[j] <= an_hist_reg[j-1];
                        end
                        an_hist_reg[0] <= fxnc_pkg::sat_samp(rnd24);
                        yout_reg       <= fxnc_pkg::sat_samp(rnd24);
                    end
                    fxnc_pkg::SRC_SECA: begin
                        spk_reg <= spk_now;
                        err_reg <= fxnc_pkg::sat_samp(AW'(d_reg) - AW'(spk_now));
                        for (int j = fxnc_pkg::WEIGHT_TAPS - 1; j > 0; j--) begin
                            err_hist_reg[j] <= err_hist_reg[j-1];
                        end
                        err_hist_reg[0] <= fxnc_pkg::sat_samp(AW'(d_reg) - AW'(spk_now));
                    end
                    fxnc_pkg::SRC_WFE:  eh_reg <= fxnc_pkg::sat_samp(rnd15);
                    fxnc_pkg::SRC_STEP: se_reg <= acc_reg[fxnc_pkg::SE_W-1:0];
                    fxnc_pkg::SRC_UPD:  se_reg <= se_reg;
                    default:            se_reg <= se_reg;
                endcase
            end
        end
    end

    // Output register: holds one finished item until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == fxnc_pkg::OP_OUT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == fxnc_pkg::OP_OUT) out_data_reg <= {eh_reg, err_reg, spk_reg, yout_reg};
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign status.out_full = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == fxnc_pkg::OP_OUT) |-> !out_valid_reg)
        else $error("result written over an item not yet taken");
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == fxnc_pkg::OP_FIN) |=> (acc_reg == '0))
        else $error("accumulator not cleared after a phase");
    a_fin_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == fxnc_pkg::OP_FIN) |-> (!p_mac_reg && !p_upd_reg))
        else $error("phase finished with a product still in flight");
`endif

endmodule

// ----- hw/rtl/fxlms_noise_canceller_core.sv -----
// Top level of the filtered-x LMS noise canceller.
// Depends on fxnc_pkg, fxnc_ctrl and fxnc_datapath.
//
// Usage:
//   Input channel s_*: one item is a reference sample and a desired sample. The block
//   takes an item only while idle. Output channel m_*: one result item per input item,
//   holding the anti-noise, the speaker output, the error and the weighted error.
//   Processing: one shared multiply-accumulate unit works through the secondary filter
//   (5 taps), weighting FIR (7), adaptive FIR (20), secondary filter (5), weighting FIR
//   (7), step product (1) and weight update (20), each phase followed by a drain step and
//   a finish step. An item is carried through to its result before the next item is
//   accepted, so the block takes no new item while one is in work; that MAC unit sets the
//   pace of the block.
//   Stalls: a finished result waits in an output register; the next item is taken and
//   processed, and its result waits until the previous one has been taken.
//   Reset (aresetn low, synchronous) clears weights and histories and loads the
//   register defaults. The user must write configuration through cfg_wen/cfg_addr/cfg_wdata
//   while idle (not enforced by the block): indexes 0 to 4 are the secondary taps, 5 is the step size.
module fxlms_noise_canceller_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: ref_sample[15:0], desired_sample[31:16].
    input  logic [2*fxnc_pkg::SAMPLE_BITS-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: anti_noise, speaker_out, error_out, weighted_error.
    output logic [4*fxnc_pkg::SAMPLE_BITS-1:0]  m_tdata,
    input  logic                                cfg_wen,
    input  logic [fxnc_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [fxnc_pkg::STEP_W-1:0]         cfg_wdata
);

    localparam int SB = fxnc_pkg::SAMPLE_BITS;

    fxnc_pkg::cmd_t    cmd;
    fxnc_pkg::status_t status;

    // Sequencer.
    fxnc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    fxnc_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_ref     (signed'(s_tdata[SB-1:0])),
        .in_desired (signed'(s_tdata[2*SB-1:SB])),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
